FILE: rtl/spq_pkg.sv
// Shared types and codes of the sorted priority queue.
package spq_pkg;

    localparam int ValueW  = 16;
    localparam int WeightW = 24;

    typedef enum logic [0:0] {
        CMD_ENQ = 1'b0,
        CMD_DEQ = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        logic               valid;
        logic [ValueW-1:0]  value;
        logic [WeightW-1:0] weight;
    } t_slot;

    typedef struct packed {
        logic               enq;
        logic               deq;
        logic               head_ins;
        logic [ValueW-1:0]  value;
        logic [WeightW-1:0] weight;
    } t_op;

endpackage

FILE: rtl/spq_cell.sv
// One slot of the sorted chain: compare, hold, insert or shift.
module spq_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_first,
    input  spq_pkg::t_op   i_op,
    input  spq_pkg::t_slot i_left,
    input  logic           i_left_shift,
    input  spq_pkg::t_slot i_right,
    output spq_pkg::t_slot o_slot,
    output logic           o_shift
);

    logic                        r_valid;
    logic [spq_pkg::ValueW-1:0]  r_value;
    logic [spq_pkg::WeightW-1:0] r_weight;

    assign o_shift = i_op.head_ins
                   || (!i_first && (!r_valid || r_weight >= i_op.weight));

    assign o_slot = '{valid: r_valid, value: r_value, weight: r_weight};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_op.enq) begin
            if (i_left_shift) begin
                r_valid <= i_left.valid;
            end else if (o_shift) begin
                r_valid <= 1'b1;
            end
        end else if (i_op.deq) begin
            r_valid <= i_right.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_op.enq) begin
            if (i_left_shift) begin
                r_value  <= i_left.value;
                r_weight <= i_left.weight;
            end else if (o_shift) begin
                r_value  <= i_op.value;
                r_weight <= i_op.weight;
            end
        end else if (i_op.deq) begin
            r_value  <= i_right.value;
            r_weight <= i_right.weight;
        end
    end

endmodule

FILE: rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue built as a chain of slot cells.
//
// Input channel s_axis: tuser bit 0 is the command (0 enqueue, 1 dequeue),
// tdata carries the entry value and weight. Every accepted word gives exactly
// one result word on m_axis: tuser is the status (ok, refused empty, refused
// full), tdata the removed head value, the empty flag and the entry count.
// Entries stay sorted by ascending weight across DEPTH cells; all cells
// compare against the new weight at once and shift or insert in the same
// cycle, so one word is taken per cycle while the output is not stalled, and
// its result appears from the output register in the cycle after acceptance.
// A new word is taken while the output register is empty or being drained
// in that cycle; when the receiver stalls the result holds and s_axis_tready
// drops until it is taken.
// Reset empties the queue and the output register and holds s_axis_tready
// low while it lasts; slot payloads are left as they are and are never read
// before being written.
module sorted_priority_queue #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // item_value[15:0], item_weight[39:16]
    input  logic [0:0]  s_axis_tuser,  // command[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // out_value[15:0], is_empty[16],
                                       // entry_count[21:17], zero pad
    output logic [1:0]  m_axis_tuser   // status[1:0]
);

    localparam int CntW = $clog2(DEPTH + 1);

    logic [CntW-1:0]   r_count;
    logic [CntW-1:0]   n_count;
    logic              r_out_valid;
    logic [15:0]       r_out_value;
    logic [1:0]        r_out_status;
    logic              r_out_empty;
    logic [4:0]        r_out_count;

    logic              w_accept;
    logic              w_full;
    logic              w_empty;
    spq_pkg::t_op      w_op;
    spq_pkg::t_slot    w_slot  [DEPTH];
    logic              w_shift [DEPTH];
    spq_pkg::t_status  w_status;
    logic [CntW+4:0]   w_cnt_ext;

    assign s_axis_tready = i_rst_n && (!r_out_valid || m_axis_tready);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_full        = (r_count == CntW'(DEPTH));
    assign w_empty       = (r_count == '0);

    always_comb begin
        w_op.value    = s_axis_tdata[15:0];
        w_op.weight   = s_axis_tdata[39:16];
        w_op.enq      = w_accept && (s_axis_tuser[0] == spq_pkg::CMD_ENQ) && !w_full;
        w_op.deq      = w_accept && (s_axis_tuser[0] == spq_pkg::CMD_DEQ) && !w_empty;
        w_op.head_ins = !w_slot[0].valid || (w_slot[0].weight > w_op.weight);
    end

    always_comb begin
        n_count  = r_count;
        w_status = spq_pkg::ST_OK;
        if (s_axis_tuser[0] == spq_pkg::CMD_ENQ) begin
            if (w_full) begin
                w_status = spq_pkg::ST_FULL;
            end else begin
                n_count = r_count + CntW'(1);
            end
        end else begin
            if (w_empty) begin
                w_status = spq_pkg::ST_EMPTY;
            end else begin
                n_count = r_count - CntW'(1);
            end
        end
    end

    assign w_cnt_ext = {5'd0, n_count};

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        spq_pkg::t_slot w_left;
        spq_pkg::t_slot w_right;
        logic           w_left_shift;
        if (g == 0) begin : g_head
            assign w_left       = '0;
            assign w_left_shift = 1'b0;
        end else begin : g_body
            assign w_left       = w_slot[g-1];
            assign w_left_shift = w_shift[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right = '0;
        end else begin : g_mid
            assign w_right = w_slot[g+1];
        end
        spq_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_first      (g == 0),
            .i_op         (w_op),
            .i_left       (w_left),
            .i_left_shift (w_left_shift),
            .i_right      (w_right),
            .o_slot       (w_slot[g]),
            .o_shift      (w_shift[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= w_op.deq ? w_slot[0].value : 16'd0;
            r_out_status <= w_status;
            r_out_empty  <= (n_count == '0);
            r_out_count  <= w_cnt_ext[4:0];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_count, r_out_empty, r_out_value};
    assign m_axis_tuser  = r_out_status;

endmodule

FILE: rtl/spq_checker.sv
// Port checker of the sorted priority queue and its bind.
module spq_port_checker #(
    parameter int DEPTH = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result word present after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result word changed");

    a_empty_flag : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_EMPTY)
            |-> m_axis_tdata[16] && (m_axis_tdata[21:17] == 5'd0)
                && (m_axis_tdata[15:0] == 16'd0))
        else $error("refused dequeue with a non-empty queue");

    a_full_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == spq_pkg::ST_FULL)
            |-> (m_axis_tdata[21:17] == 5'(DEPTH)) && !m_axis_tdata[16]
                && (m_axis_tdata[15:0] == 16'd0))
        else $error("refused enqueue with a queue that is not full");

    a_no_accept_stall : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
        else $error("accepted word gave no result");

endmodule

bind sorted_priority_queue spq_port_checker #(.DEPTH(DEPTH)) u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: test/spq_checker.sv
// Checker that predicts every result word of the sorted priority queue and compares it.
module spq_checker #(
    parameter int DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [39:0] i_s_tdata,   // item_value[15:0], item_weight[39:16]
    input  logic [0:0]  i_s_tuser,   // command[0]
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [23:0] i_m_tdata,   // out_value[15:0], is_empty[16], entry_count[21:17]
    input  logic [1:0]  i_m_tuser,   // status[1:0]
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked,
    output int          o_refused_full,
    output int          o_refused_empty
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [spq_pkg::ValueW-1:0] value;
        spq_pkg::t_status           status;
        logic                       empty;
        logic [4:0]                 count;
    } t_result;

    logic [spq_pkg::ValueW-1:0]  slot_val [DEPTH];
    logic [spq_pkg::WeightW-1:0] slot_wt  [DEPTH];
    int                          held = 0;

    t_result result_q [$];
    t_result want;
    t_result got;
    t_result step_res;
    int      fail_count    = 0;
    int      checked       = 0;
    int      refused_full  = 0;
    int      refused_empty = 0;

    task automatic queue_step(input spq_pkg::t_cmd cmd,
                              input logic [spq_pkg::ValueW-1:0] val,
                              input logic [spq_pkg::WeightW-1:0] wt,
                              output t_result res);
        int pos;
        int i;
        res.value  = '0;
        res.status = spq_pkg::ST_OK;
        if (cmd == spq_pkg::CMD_ENQ) begin
            if (held >= DEPTH) begin
                res.status = spq_pkg::ST_FULL;
            end else begin
                // new entry goes ahead of the head only when the head is strictly heavier
                if (held == 0 || slot_wt[0] > wt) begin
                    pos = 0;
                end else begin
                    pos = 1;
                    while (pos < held && slot_wt[pos] < wt) pos++;
                end
                for (i = held; i > pos; i--) begin
                    slot_val[i] = slot_val[i-1];
                    slot_wt[i]  = slot_wt[i-1];
                end
                slot_val[pos] = val;
                slot_wt[pos]  = wt;
                held++;
            end
        end else begin
            if (held == 0) begin
                res.status = spq_pkg::ST_EMPTY;
            end else begin
                res.value = slot_val[0];
                for (i = 1; i < held; i++) begin
                    slot_val[i-1] = slot_val[i];
                    slot_wt[i-1]  = slot_wt[i];
                end
                held--;
            end
        end
        res.empty = (held == 0);
        res.count = 5'(held);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held = 0;
            result_q.delete();
        end else begin
            // compare before predicting: a result never belongs to the word taken at this edge
            if (i_m_tvalid && i_m_tready) begin
                got.value  = i_m_tdata[15:0];
                got.empty  = i_m_tdata[16];
                got.count  = i_m_tdata[21:17];
                got.status = spq_pkg::t_status'(i_m_tuser);
                if (result_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: unexpected result word value %h status %0d %s %0d %s %0d",
                                 $realtime, got.value, got.status, "empty", got.empty,
                                 "count", got.count);
                end else begin
                    want = result_q.pop_front();
                    checked++;
                    if (got !== want) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch, expected value %h status %0d %s %0d %s %0d,",
                                     $realtime, want.value, want.status, "empty",
                                     want.empty, "count", want.count,
                                     " got value %h status %0d empty %0d count %0d",
                                     got.value, got.status, got.empty, got.count);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                queue_step(spq_pkg::t_cmd'(i_s_tuser), i_s_tdata[15:0], i_s_tdata[39:16],
                           step_res);
                result_q.push_back(step_res);
                if (step_res.status == spq_pkg::ST_FULL) refused_full++;
                if (step_res.status == spq_pkg::ST_EMPTY) refused_empty++;
            end
        end
        o_fail_count    <= fail_count;
        o_pending       <= result_q.size();
        o_checked       <= checked;
        o_refused_full  <= refused_full;
        o_refused_empty <= refused_empty;
    end

endmodule

FILE: test/sorted_priority_queue_tb.sv
// Testbench top of the sorted priority queue: stimulus, idling phases and verdict.
module sorted_priority_queue_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_PER_PHASE = 134;

    typedef enum int {
        BURST_FILL,
        BURST_DRAIN,
        BURST_MIX
    } t_burst;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;   // item_value[15:0], item_weight[39:16]
    logic [0:0]  s_axis_tuser;   // command[0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // out_value[15:0], is_empty[16], entry_count[21:17], zero pad
    logic [1:0]  m_axis_tuser;   // status[1:0]

    int fail_count;
    int pending;
    int checked;
    int refused_full;
    int refused_empty;
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;

    sorted_priority_queue #(.DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    spq_checker #(.DEPTH(DEPTH)) u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_tvalid      (s_axis_tvalid),
        .i_s_tready      (s_axis_tready),
        .i_s_tdata       (s_axis_tdata),
        .i_s_tuser       (s_axis_tuser),
        .i_m_tvalid      (m_axis_tvalid),
        .i_m_tready      (m_axis_tready),
        .i_m_tdata       (m_axis_tdata),
        .i_m_tuser       (m_axis_tuser),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked),
        .o_refused_full  (refused_full),
        .o_refused_empty (refused_empty)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Run exceeded %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    task automatic send_word(input spq_pkg::t_cmd cmd, input logic [15:0] val,
                             input logic [23:0] wt);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {wt, val};
        s_axis_tuser  <= cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_weight();
        unique case ($urandom_range(3, 0))
            0:       return 24'($urandom_range(7, 0));
            1:       return $urandom_range(1, 0) ? 24'hFFFFFF : 24'h000000;
            default: return 24'($urandom);
        endcase
    endfunction

    task automatic run_random(input int n);
        t_burst mode;
        int     burst_left;
        int     enq_pct;
        int     k;
        burst_left = 0;
        enq_pct    = 50;
        for (k = 0; k < n; k++) begin
            if (burst_left == 0) begin
                mode       = t_burst'($urandom_range(2, 0));
                burst_left = $urandom_range(24, 6);
                unique case (mode)
                    BURST_FILL:  enq_pct = 80;
                    BURST_DRAIN: enq_pct = 20;
                    default:     enq_pct = 50;
                endcase
            end
            burst_left--;
            send_word(($urandom_range(99, 0) < enq_pct) ? spq_pkg::CMD_ENQ : spq_pkg::CMD_DEQ,
                      16'($urandom), pick_weight());
        end
    endtask

    initial begin
        int k;
        i_clk         = 1'b0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = spq_pkg::CMD_ENQ;
        m_axis_tready = 1'b0;
        send_idle_pct = 35;
        recv_idle_pct = 87;
        words_sent    = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // dequeue on empty, extreme fields, head insertion and ties with the head
        send_word(spq_pkg::CMD_DEQ, 16'hFFFF, 24'hFFFFFF);
        send_word(spq_pkg::CMD_ENQ, 16'h0000, 24'hFFFFFF);
        send_word(spq_pkg::CMD_ENQ, 16'hFFFF, 24'h000000);
        send_word(spq_pkg::CMD_ENQ, 16'h0001, 24'h000000);
        send_word(spq_pkg::CMD_ENQ, 16'h0002, 24'h000000);
        for (k = 0; k < DEPTH - 4; k++)
            send_word(spq_pkg::CMD_ENQ, 16'($urandom), 24'($urandom_range(3, 0)));
        send_word(spq_pkg::CMD_ENQ, 16'hA5A5, 24'h000001);
        for (k = 0; k < 4; k++)
            send_word(spq_pkg::CMD_DEQ, 16'($urandom), 24'($urandom));

        wait_drained();
        run_random(RANDOM_PER_PHASE);

        send_idle_pct = 87;
        recv_idle_pct = 35;
        wait_drained();
        run_random(RANDOM_PER_PHASE / 2);
        wait_drained();
        run_random(RANDOM_PER_PHASE / 2);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_PER_PHASE);

        wait_drained();
        repeat (8) @(posedge i_clk);

        $display("Sent %0d command words over three idling phases, %0d results checked.",
                 words_sent, checked);
        $display("Enqueues refused on full: %0d, dequeues refused on empty: %0d.",
                 refused_full, refused_empty);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/sorted_priority_queue.sv
rtl/spq_checker.sv
test/spq_checker.sv
test/sorted_priority_queue_tb.sv
